@@ design/aarm_pkg.sv @@
// Shared constants, types and the arctangent table of the axis-angle rotation matrix block.
`default_nettype none

package aarm_pkg;

  // Fixed-point formats and iteration counts.
  localparam int FRAC_BITS    = 14;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int FIELD_W      = 16;

  // Pipeline depths of the units; the angle waits for the norm path.
  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_LAT   = SQRT_STEPS + 1;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int CORDIC_LAT = CORDIC_STEPS + 2;
  localparam int ANG_DLY    = SQRT_LAT + DIV_LAT - CORDIC_LAT;

  // CORDIC start value, the gain for unbounded steps in Q30.
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Axis information that rides alongside the square root.
  typedef struct packed {
    logic [FIELD_W-1:0] mag_x;
    logic [FIELD_W-1:0] mag_y;
    logic [FIELD_W-1:0] mag_z;
    logic               neg_x;
    logic               neg_y;
    logic               neg_z;
    logic               zero;
  } axis_side_t;

  // Arctangent of 2^-k in units where 2^32 is one turn.
  function automatic logic [29:0] atan_turn(input int k);
    logic [29:0] a;
    case (k)
      0:  a = 30'd536870912;
      1:  a = 30'd316933406;
      2:  a = 30'd167458909;
      3:  a = 30'd85004756;
      4:  a = 30'd42667331;
      5:  a = 30'd21354465;
      6:  a = 30'd10679838;
      7:  a = 30'd5340245;
      8:  a = 30'd2670163;
      9:  a = 30'd1335087;
      10: a = 30'd667544;
      11: a = 30'd333772;
      12: a = 30'd166886;
      13: a = 30'd83443;
      14: a = 30'd41722;
      15: a = 30'd20861;
      16: a = 30'd10430;
      17: a = 30'd5215;
      18: a = 30'd2608;
      19: a = 30'd1304;
      20: a = 30'd652;
      21: a = 30'd326;
      22: a = 30'd163;
      23: a = 30'd81;
      24: a = 30'd41;
      25: a = 30'd20;
      26: a = 30'd10;
      27: a = 30'd5;
      28: a = 30'd3;
      29: a = 30'd1;
      30: a = 30'd1;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

@@ design/axis_angle_rotation_matrix_top.sv @@
// Top level of the axis-angle rotation matrix block.
//
// An item is transferred in at a rising edge where start is high and busy is
// low; busy is never raised, so an item may be given in every cycle. The item
// is a 16-bit binary angle and a 3-D axis of any length.
// Each result is a transfer on the out_ ports marked by out_valid for one
// cycle: nine Q1.14 matrix elements saturated to plus or minus one, and
// out_zero_axis, which is set (with the identity) for an all-zero axis.
// Throughput is one item per cycle. From the accepting edge to out_valid an
// item passes the two input stages, the 33-stage square root and the
// 33-stage divider that normalise the axis; the CORDIC sine and cosine run
// beside them on a delayed copy of the angle, followed by two multiply
// stages, an add stage and an output stage.
// Synchronous reset clears all valid bits, so no result appears after reset
// until items are given. The receiver cannot hold results off and none is
// needed: every result is presented exactly once.
`default_nettype none

module axis_angle_rotation_matrix_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [15:0] in_angle,
  input  wire logic [15:0] in_axis_x,
  input  wire logic [15:0] in_axis_y,
  input  wire logic [15:0] in_axis_z,
  output logic             out_valid,
  output logic [15:0]      out_r00,
  output logic [15:0]      out_r01,
  output logic [15:0]      out_r02,
  output logic [15:0]      out_r10,
  output logic [15:0]      out_r11,
  output logic [15:0]      out_r12,
  output logic [15:0]      out_r20,
  output logic [15:0]      out_r21,
  output logic [15:0]      out_r22,
  output logic             out_zero_axis
);

  localparam int DLY = aarm_pkg::ANG_DLY;

  logic               v1_r;
  logic [15:0]        ang1_r;
  logic signed [15:0] ax1_r;
  logic signed [15:0] ay1_r;
  logic signed [15:0] az1_r;
  logic               v2_r;
  logic [15:0]        ang2_r;
  logic [31:0]        sqx_r;
  logic [31:0]        sqy_r;
  logic [31:0]        sqz_r;
  aarm_pkg::axis_side_t side2_r;
  logic [31:0]        n2_c;
  logic [15:0]        ang_dly_r [DLY];
  logic               vld_dly_r [DLY];

  logic               sq_vld;
  logic [30:0]        sq_root;
  aarm_pkg::axis_side_t sq_side;
  logic               dv_vld;
  logic signed [31:0] ux;
  logic signed [31:0] uy;
  logic signed [31:0] uz;
  logic               dv_zero;
  logic               cr_vld;
  logic signed [31:0] sin_q;
  logic signed [31:0] cos_q;
  logic [15:0]        elem [9];

  assign busy = 1'b0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    ang1_r <= in_angle;
    ax1_r  <= in_axis_x;
    ay1_r  <= in_axis_y;
    az1_r  <= in_axis_z;
  end

  // Squares, magnitudes and the zero-axis flag.
  always_ff @(posedge clk) begin
    ang2_r        <= ang1_r;
    sqx_r         <= 32'(ax1_r * ax1_r);
    sqy_r         <= 32'(ay1_r * ay1_r);
    sqz_r         <= 32'(az1_r * az1_r);
    side2_r.mag_x <= ax1_r[15] ? 16'(-ax1_r) : ax1_r;
    side2_r.mag_y <= ay1_r[15] ? 16'(-ay1_r) : ay1_r;
    side2_r.mag_z <= az1_r[15] ? 16'(-az1_r) : az1_r;
    side2_r.neg_x <= ax1_r[15];
    side2_r.neg_y <= ay1_r[15];
    side2_r.neg_z <= az1_r[15];
    side2_r.zero  <= (ax1_r == '0) && (ay1_r == '0) && (az1_r == '0);
  end

  assign n2_c = sqx_r + sqy_r + sqz_r;

  // Angle delay line so that sine and cosine meet the unit axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DLY; i++) begin
        vld_dly_r[i] <= 1'b0;
      end
    end else begin
      vld_dly_r[0] <= v2_r;
      for (int i = 1; i < DLY; i++) begin
        vld_dly_r[i] <= vld_dly_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    ang_dly_r[0] <= ang2_r;
    for (int i = 1; i < DLY; i++) begin
      ang_dly_r[i] <= ang_dly_r[i-1];
    end
  end

  aarm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (v2_r),
    .n2       (n2_c),
    .side_in  (side2_r),
    .out_vld  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  aarm_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (sq_vld),
    .root    (sq_root),
    .side_in (sq_side),
    .out_vld (dv_vld),
    .unit_x  (ux),
    .unit_y  (uy),
    .unit_z  (uz),
    .zero    (dv_zero)
  );

  aarm_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (vld_dly_r[DLY-1]),
    .angle   (ang_dly_r[DLY-1]),
    .out_vld (cr_vld),
    .sin_q   (sin_q),
    .cos_q   (cos_q)
  );

  aarm_matrix u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (dv_vld),
    .zero     (dv_zero),
    .unit_x   (ux),
    .unit_y   (uy),
    .unit_z   (uz),
    .sin_q    (sin_q),
    .cos_q    (cos_q),
    .out_vld  (out_valid),
    .out_zero (out_zero_axis),
    .elem     (elem)
  );

  assign out_r00 = elem[0];
  assign out_r01 = elem[1];
  assign out_r02 = elem[2];
  assign out_r10 = elem[3];
  assign out_r11 = elem[4];
  assign out_r12 = elem[5];
  assign out_r20 = elem[6];
  assign out_r21 = elem[7];
  assign out_r22 = elem[8];

  // The sine and cosine path must line up with the normalised axis.
  a_path_align: assert property (@(posedge clk) disable iff (!rst_n)
    cr_vld == dv_vld)
    else $error("CORDIC and divider valid bits out of step");

  // A zero axis must give ones on the diagonal.
  a_zero_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_axis |->
      out_r00 == 16'(1 << aarm_pkg::FRAC_BITS) && out_r11 == out_r00 && out_r22 == out_r00)
    else $error("zero axis without unit diagonal");

  // A zero axis must give zeros off the diagonal.
  a_zero_off: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_axis |->
      out_r01 == '0 && out_r02 == '0 && out_r10 == '0 &&
      out_r12 == '0 && out_r20 == '0 && out_r21 == '0)
    else $error("zero axis with nonzero off-diagonal element");

endmodule

`default_nettype wire

@@ design/aarm_sqrt.sv @@
// Pipelined integer square root of the squared axis length, one result bit per stage.
`default_nettype none

module aarm_sqrt (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  input  wire logic [31:0]           n2,
  input  wire aarm_pkg::axis_side_t  side_in,
  output logic                       out_vld,
  output logic [30:0]                root,
  output aarm_pkg::axis_side_t       side_out
);

  localparam int STEPS = aarm_pkg::SQRT_STEPS;

  logic [62:0]          v_r    [STEPS+1];
  logic [62:0]          rt_r   [STEPS+1];
  logic                 vld_r  [STEPS+1];
  aarm_pkg::axis_side_t side_r [STEPS+1];

  // Input stage: the radicand is the squared length scaled by 2^30.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    v_r[0]    <= {1'b0, n2, 30'b0};
    rt_r[0]   <= '0;
    side_r[0] <= side_in;
  end

  // One digit step per stage, the trial bit fixed by the stage position.
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * g);
    logic [62:0] sum_c;
    logic [62:0] v_nxt;
    logic [62:0] rt_nxt;

    always_comb begin
      sum_c = rt_r[g] + BIT;
      if (v_r[g] >= sum_c) begin
        v_nxt  = v_r[g] - sum_c;
        rt_nxt = (rt_r[g] >> 1) + BIT;
      end else begin
        v_nxt  = v_r[g];
        rt_nxt = rt_r[g] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      v_r[g+1]    <= v_nxt;
      rt_r[g+1]   <= rt_nxt;
      side_r[g+1] <= side_r[g];
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign root     = rt_r[STEPS][30:0];
  assign side_out = side_r[STEPS];

endmodule

`default_nettype wire

@@ design/aarm_div.sv @@
// Pipelined restoring divider that turns the three axis components into a unit vector in Q30.
`default_nettype none

module aarm_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_vld,
  input  wire logic [30:0]           root,
  input  wire aarm_pkg::axis_side_t  side_in,
  output logic                       out_vld,
  output logic signed [31:0]         unit_x,
  output logic signed [31:0]         unit_y,
  output logic signed [31:0]         unit_z,
  output logic                       zero
);

  localparam int STEPS = aarm_pkg::DIV_STEPS;

  logic [60:0] rem_r  [STEPS+1][3];
  logic [30:0] quo_r  [STEPS+1][3];
  logic [30:0] dvs_r  [STEPS+1];
  logic [2:0]  neg_r  [STEPS+1];
  logic        zero_r [STEPS+1];
  logic        vld_r  [STEPS+1];
  logic [15:0] mag_c  [3];
  logic signed [31:0] unit_r [3];
  logic        zero_o_r;
  logic        vld_o_r;

  assign mag_c[0] = side_in.mag_x;
  assign mag_c[1] = side_in.mag_y;
  assign mag_c[2] = side_in.mag_z;

  // Input stage: dividend is |a| * 2^45 plus half the divisor for rounding.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      rem_r[0][l] <= (61'(mag_c[l]) << 45) + 61'(root >> 1);
      quo_r[0][l] <= '0;
    end
    dvs_r[0]  <= root;
    neg_r[0]  <= {side_in.neg_z, side_in.neg_y, side_in.neg_x};
    zero_r[0] <= side_in.zero;
  end

  // One quotient bit per stage in each of the three lanes.
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam int K = STEPS - 1 - g;
    logic [60:0] dsh_c;
    logic [60:0] rem_nxt [3];
    logic [30:0] quo_nxt [3];

    always_comb begin
      dsh_c = 61'(dvs_r[g]) << K;
      for (int l = 0; l < 3; l++) begin
        if (rem_r[g][l] >= dsh_c) begin
          rem_nxt[l] = rem_r[g][l] - dsh_c;
          quo_nxt[l] = quo_r[g][l] | (31'(1) << K);
        end else begin
          rem_nxt[l] = rem_r[g][l];
          quo_nxt[l] = quo_r[g][l];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g+1]  <= rem_nxt;
      quo_r[g+1]  <= quo_nxt;
      dvs_r[g+1]  <= dvs_r[g];
      neg_r[g+1]  <= neg_r[g];
      zero_r[g+1] <= zero_r[g];
    end
  end

  // Output stage: restore the sign of each component.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else begin
      vld_o_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      unit_r[l] <= neg_r[STEPS][l] ? -$signed({1'b0, quo_r[STEPS][l]})
                                   : $signed({1'b0, quo_r[STEPS][l]});
    end
    zero_o_r <= zero_r[STEPS];
  end

  assign out_vld = vld_o_r;
  assign unit_x  = unit_r[0];
  assign unit_y  = unit_r[1];
  assign unit_z  = unit_r[2];
  assign zero    = zero_o_r;

endmodule

`default_nettype wire

@@ design/aarm_cordic.sv @@
// Pipelined CORDIC rotator giving the sine and cosine of a binary angle in Q30.
`default_nettype none

module aarm_cordic (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_vld,
  input  wire logic [aarm_pkg::FIELD_W-1:0] angle,
  output logic                            out_vld,
  output logic signed [31:0]              sin_q,
  output logic signed [31:0]              cos_q
);

  localparam int STEPS = aarm_pkg::CORDIC_STEPS;
  localparam logic [63:0] AMASK = (64'd1 << aarm_pkg::ANGLE_BITS) - 64'd1;
  localparam logic signed [32:0] QTURN = 33'sd1073741824;
  localparam logic signed [32:0] HTURN = 33'sd2147483648;

  logic signed [33:0] x_r   [STEPS+1];
  logic signed [33:0] y_r   [STEPS+1];
  logic signed [32:0] z_r   [STEPS+1];
  logic               neg_r [STEPS+1];
  logic               vld_r [STEPS+1];
  logic [31:0]        ph_c;
  logic signed [32:0] z_c;
  logic signed [32:0] zf_c;
  logic               neg_c;
  logic signed [31:0] sin_r;
  logic signed [31:0] cos_r;
  logic               vld_o_r;

  // Phase fold: beyond a quarter turn, move by half a turn and negate later.
  always_comb begin
    ph_c = 32'((64'(angle) & AMASK) << (32 - aarm_pkg::ANGLE_BITS));
    z_c  = 33'($signed(ph_c));
    if (z_c > QTURN) begin
      zf_c  = z_c - HTURN;
      neg_c = 1'b1;
    end else if (z_c < -QTURN) begin
      zf_c  = z_c + HTURN;
      neg_c = 1'b1;
    end else begin
      zf_c  = z_c;
      neg_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    x_r[0]   <= aarm_pkg::CORDIC_GAIN;
    y_r[0]   <= '0;
    z_r[0]   <= zf_c;
    neg_r[0] <= neg_c;
  end

  // One micro-rotation per stage.
  for (genvar g = 0; g < STEPS; g++) begin : g_step
    localparam logic signed [32:0] ATN = $signed({3'b0, aarm_pkg::atan_turn(g)});
    logic signed [33:0] dx_c;
    logic signed [33:0] dy_c;
    logic signed [33:0] x_nxt;
    logic signed [33:0] y_nxt;
    logic signed [32:0] z_nxt;

    always_comb begin
      dx_c = y_r[g] >>> g;
      dy_c = x_r[g] >>> g;
      if (!z_r[g][32]) begin
        x_nxt = x_r[g] - dx_c;
        y_nxt = y_r[g] + dy_c;
        z_nxt = z_r[g] - ATN;
      end else begin
        x_nxt = x_r[g] + dx_c;
        y_nxt = y_r[g] - dy_c;
        z_nxt = z_r[g] + ATN;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      x_r[g+1]   <= x_nxt;
      y_r[g+1]   <= y_nxt;
      z_r[g+1]   <= z_nxt;
      neg_r[g+1] <= neg_r[g];
    end
  end

  // Output stage: undo the fold.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_o_r <= 1'b0;
    end else begin
      vld_o_r <= vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    cos_r <= 32'(neg_r[STEPS] ? -x_r[STEPS] : x_r[STEPS]);
    sin_r <= 32'(neg_r[STEPS] ? -y_r[STEPS] : y_r[STEPS]);
  end

  assign out_vld = vld_o_r;
  assign sin_q   = sin_r;
  assign cos_q   = cos_r;

endmodule

`default_nettype wire

@@ design/aarm_matrix.sv @@
// Multiply and add stages that build the Rodrigues matrix and round it to the output format.
`default_nettype none

module aarm_matrix (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_vld,
  input  wire logic                zero,
  input  wire logic signed [31:0]  unit_x,
  input  wire logic signed [31:0]  unit_y,
  input  wire logic signed [31:0]  unit_z,
  input  wire logic signed [31:0]  sin_q,
  input  wire logic signed [31:0]  cos_q,
  output logic                     out_vld,
  output logic                     out_zero,
  output logic [aarm_pkg::FIELD_W-1:0] elem [9]
);

  localparam int SH = 30 - aarm_pkg::FRAC_BITS;
  localparam logic signed [35:0] RND = (SH > 0) ? (36'sd1 <<< (SH - 1)) : 36'sd0;
  localparam logic signed [35:0] ONE = 36'sd1 <<< aarm_pkg::FRAC_BITS;
  localparam logic signed [33:0] Q30_ONE = 34'sd1073741824;

  // Q30 product, rounded half up.
  function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + 68'sd536870912;
    return 34'(p >>> 30);
  endfunction

  // Round to the output fraction and saturate to plus or minus one.
  function automatic logic [aarm_pkg::FIELD_W-1:0] to_out(input logic signed [34:0] v);
    logic signed [35:0] w;
    w = (36'(v) + RND) >>> SH;
    if (w > ONE) begin
      w = ONE;
    end else if (w < -ONE) begin
      w = -ONE;
    end
    return aarm_pkg::FIELD_W'(w);
  endfunction

  logic signed [33:0] u_c [3];
  logic signed [33:0] p_r [6];
  logic signed [33:0] sk1_r [3];
  logic signed [33:0] t_r;
  logic signed [33:0] c1_r;
  logic               z1_r;
  logic               v1_r;
  logic signed [33:0] m_r [6];
  logic signed [33:0] sk2_r [3];
  logic signed [33:0] c2_r;
  logic               z2_r;
  logic               v2_r;
  logic signed [34:0] e_r [9];
  logic               z3_r;
  logic               v3_r;
  logic [aarm_pkg::FIELD_W-1:0] o_r [9];
  logic               z4_r;
  logic               v4_r;

  assign u_c[0] = 34'(unit_x);
  assign u_c[1] = 34'(unit_y);
  assign u_c[2] = 34'(unit_z);

  // Valid bits of the four stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Stage one: outer products of the unit axis, sine terms and one minus cosine.
  always_ff @(posedge clk) begin
    p_r[0] <= mul_q30(u_c[0], u_c[0]);
    p_r[1] <= mul_q30(u_c[0], u_c[1]);
    p_r[2] <= mul_q30(u_c[0], u_c[2]);
    p_r[3] <= mul_q30(u_c[1], u_c[1]);
    p_r[4] <= mul_q30(u_c[1], u_c[2]);
    p_r[5] <= mul_q30(u_c[2], u_c[2]);
    for (int l = 0; l < 3; l++) begin
      sk1_r[l] <= mul_q30(34'(sin_q), u_c[l]);
    end
    t_r  <= Q30_ONE - 34'(cos_q);
    c1_r <= 34'(cos_q);
    z1_r <= zero;
  end

  // Stage two: scale the symmetric part by one minus cosine.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 6; l++) begin
      m_r[l] <= mul_q30(t_r, p_r[l]);
    end
    sk2_r <= sk1_r;
    c2_r  <= c1_r;
    z2_r  <= z1_r;
  end

  // Stage three: add the identity scaled by cosine and the skew part.
  always_ff @(posedge clk) begin
    e_r[0] <= 35'(m_r[0]) + 35'(c2_r);
    e_r[1] <= 35'(m_r[1]) - 35'(sk2_r[2]);
    e_r[2] <= 35'(m_r[2]) + 35'(sk2_r[1]);
    e_r[3] <= 35'(m_r[1]) + 35'(sk2_r[2]);
    e_r[4] <= 35'(m_r[3]) + 35'(c2_r);
    e_r[5] <= 35'(m_r[4]) - 35'(sk2_r[0]);
    e_r[6] <= 35'(m_r[2]) - 35'(sk2_r[1]);
    e_r[7] <= 35'(m_r[4]) + 35'(sk2_r[0]);
    e_r[8] <= 35'(m_r[5]) + 35'(c2_r);
    z3_r   <= z2_r;
  end

  // Stage four: output format; a zero axis gives the identity.
  always_ff @(posedge clk) begin
    for (int l = 0; l < 9; l++) begin
      if (z3_r) begin
        o_r[l] <= (l % 4 == 0) ? aarm_pkg::FIELD_W'(ONE) : '0;
      end else begin
        o_r[l] <= to_out(e_r[l]);
      end
    end
    z4_r <= z3_r;
  end

  assign out_vld  = v4_r;
  assign out_zero = z4_r;
  assign elem     = o_r;

endmodule

`default_nettype wire
